// ----- src/mcp_pkg.sv -----
// ----------------------------------------------------------------------------
// mcp_pkg
// Types and constants shared by the MIDI channel message parser.
// ----------------------------------------------------------------------------
package mcp_pkg;

  typedef enum logic [2:0] {
    KIND_NOTE_OFF   = 3'd0,
    KIND_NOTE_ON    = 3'd1,
    KIND_CTRL_CHG   = 3'd2,
    KIND_PROG_CHG   = 3'd3,
    KIND_CHAN_PRESS = 3'd4,
    KIND_PITCH_BEND = 3'd5
  } msg_kind_e;

  localparam logic [3:0] STAT_NOTE_OFF   = 4'h8;
  localparam logic [3:0] STAT_NOTE_ON    = 4'h9;
  localparam logic [3:0] STAT_CTRL_CHG   = 4'hB;
  localparam logic [3:0] STAT_PROG_CHG   = 4'hC;
  localparam logic [3:0] STAT_CHAN_PRESS = 4'hD;
  localparam logic [3:0] STAT_PITCH_BEND = 4'hE;

  localparam int unsigned BendShift = 7;

  typedef struct packed {
    logic [7:0] midi_byte;
  } midi_byte_t;

  typedef struct packed {
    msg_kind_e   msg_kind;
    logic [3:0]  channel;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [14:0] bend_value;
  } midi_msg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] midi_byte;
  } in_stage_t;

endpackage

// ----- src/mcp_stream_if.sv -----
// ----------------------------------------------------------------------------
// mcp_stream_if
// Valid/ready stream channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface mcp_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/mcp_in_reg.sv -----
// ----------------------------------------------------------------------------
// mcp_in_reg
// Input register stage holding one received byte until the decoder takes it.
// ----------------------------------------------------------------------------
module mcp_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [7:0]        byte_i,
  input  logic              adv_i,
  output mcp_pkg::in_stage_t stage_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       take;

  assign ready_o = !valid_q || adv_i;
  assign take    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (take) begin
      valid_d = 1'b1;
      byte_d  = byte_i;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign stage_o.valid     = valid_q;
  assign stage_o.midi_byte = byte_q;

endmodule

// ----- src/mcp_core.sv -----
// ----------------------------------------------------------------------------
// mcp_core
// Message assembly state, decode and the result register.
// ----------------------------------------------------------------------------
module mcp_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mcp_pkg::in_stage_t stage_i,
  output logic               adv_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mcp_pkg::midi_msg_t out_data_o
);

  logic               building_q, building_d;
  logic [1:0]         held_q, held_d;
  logic [7:0]         status_q, status_d;
  logic [7:0]         first_q, first_d;
  logic               out_valid_q, out_valid_d;
  mcp_pkg::midi_msg_t out_q, out_d;

  logic               fire;
  logic               bld;
  logic [1:0]         cnt;
  logic [1:0]         count;
  logic [7:0]         b;
  logic [7:0]         second;
  logic               supported;
  logic [1:0]         need;
  logic               emit;
  mcp_pkg::msg_kind_e kind;
  mcp_pkg::midi_msg_t msg;
  logic [14:0]        bend;

  assign adv_o = !out_valid_q || out_ready_i;
  assign fire  = stage_i.valid && adv_o;
  assign b     = stage_i.midi_byte;

  always_comb begin
    bld      = building_q || b[7];
    cnt      = building_q ? held_q : 2'd0;
    count    = cnt + 2'd1;
    status_d = status_q;
    first_d  = first_q;
    second   = '0;
    if (fire && bld) begin
      unique case (cnt)
        2'd0:    status_d = b;
        2'd1:    first_d  = b;
        default: second   = b;
      endcase
    end
  end

  always_comb begin
    kind      = mcp_pkg::KIND_NOTE_OFF;
    need      = 2'd3;
    supported = 1'b1;
    unique case (status_d[7:4])
      mcp_pkg::STAT_NOTE_OFF:   kind = mcp_pkg::KIND_NOTE_OFF;
      mcp_pkg::STAT_NOTE_ON:    kind = mcp_pkg::KIND_NOTE_ON;
      mcp_pkg::STAT_CTRL_CHG:   kind = mcp_pkg::KIND_CTRL_CHG;
      mcp_pkg::STAT_PROG_CHG: begin
        kind = mcp_pkg::KIND_PROG_CHG;
        need = 2'd2;
      end
      mcp_pkg::STAT_CHAN_PRESS: begin
        kind = mcp_pkg::KIND_CHAN_PRESS;
        need = 2'd2;
      end
      mcp_pkg::STAT_PITCH_BEND: kind = mcp_pkg::KIND_PITCH_BEND;
      default:                  supported = 1'b0;
    endcase
  end

  // bend value from the two data bytes
  assign bend = {7'd0, first_d} | ({7'd0, second} << mcp_pkg::BendShift);

  always_comb begin
    emit       = 1'b0;
    building_d = building_q;
    held_d     = held_q;
    if (fire && bld) begin
      if (!supported) begin
        building_d = 1'b0;
        held_d     = 2'd0;
      end else if (count < need) begin
        building_d = 1'b1;
        held_d     = count;
      end else begin
        emit       = 1'b1;
        building_d = 1'b0;
        held_d     = 2'd0;
      end
    end
  end

  always_comb begin
    msg.msg_kind = kind;
    msg.channel  = status_d[3:0];
    if (kind == mcp_pkg::KIND_PITCH_BEND) begin
      msg.first_data  = '0;
      msg.second_data = '0;
      msg.bend_value  = bend;
    end else begin
      msg.first_data  = first_d;
      msg.second_data = (need == 2'd3) ? second : 8'd0;
      msg.bend_value  = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (adv_o) begin
      out_valid_d = emit;
      out_d       = msg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      building_q  <= 1'b0;
      held_q      <= 2'd0;
      status_q    <= 8'd0;
      first_q     <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      building_q  <= building_d;
      held_q      <= held_d;
      status_q    <= status_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- src/midi_channel_message_parser.sv -----
// ----------------------------------------------------------------------------
// midi_channel_message_parser
// Assembles received MIDI bytes into decoded channel messages.
// ----------------------------------------------------------------------------
// path: a result is registered after its last byte leaves the input register
// throughput: one byte per cycle while the output is not stalled, set by the
//   single decode step between the input register and the result register
// reset: asynchronous, clears the message state and both valid flags
module midi_channel_message_parser (
  input  logic         clk_i,
  input  logic         rst_ni,
  mcp_stream_if.sink   byte_in,
  mcp_stream_if.source msg_out
);

  mcp_pkg::in_stage_t stage;
  mcp_pkg::midi_byte_t in_data;
  mcp_pkg::midi_msg_t  out_data;
  logic               adv;

  assign in_data = byte_in.data;

  mcp_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (byte_in.valid),
    .ready_o (byte_in.ready),
    .byte_i  (in_data.midi_byte),
    .adv_i   (adv),
    .stage_o (stage)
  );

  mcp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_i     (stage),
    .adv_o       (adv),
    .out_valid_o (msg_out.valid),
    .out_ready_i (msg_out.ready),
    .out_data_o  (out_data)
  );

  assign msg_out.data = out_data;

  a_bend_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    msg_out.valid && out_data.msg_kind == mcp_pkg::KIND_PITCH_BEND
    |-> out_data.first_data == 8'd0 && out_data.second_data == 8'd0)
    else $error("pitch bend carries data bytes");

  a_no_bend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    msg_out.valid && out_data.msg_kind != mcp_pkg::KIND_PITCH_BEND
    |-> out_data.bend_value == 15'd0)
    else $error("bend value on non bend message");

  a_two_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    msg_out.valid && (out_data.msg_kind == mcp_pkg::KIND_PROG_CHG ||
                      out_data.msg_kind == mcp_pkg::KIND_CHAN_PRESS)
    |-> out_data.second_data == 8'd0)
    else $error("second byte on two byte message");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !msg_out.valid |-> byte_in.ready)
    else $error("input stalled with empty output");

endmodule
